// ===== rtl/core/mp3ar_pkg.sv =====
`timescale 1ns / 1ps
package mp3ar_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W = 16;
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int SUM_W = PROD_W + 1;
  localparam int IDX_W = 10;
  localparam int MODE_W = 2;
  localparam int NUM_COEF = 8;
  localparam int COEF_IDX_W = 3;
  localparam int REG_W = 32;
  localparam int QDEPTH = 8;
  localparam int QPTR_W = 3;
  localparam int QCNT_W = 4;
  localparam int FRAC_BITS = 15;

  typedef enum logic [MODE_W-1:0] {
    MODE_LONG  = 2'd0,
    MODE_MIXED = 2'd1,
    MODE_SHORT = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_PASS = 1'b0,
    KIND_BFLY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic signed [SAMPLE_W-1:0]  x;
    logic signed [SAMPLE_W-1:0]  u;
    logic [COEF_IDX_W-1:0]       sel;
    logic [IDX_W-1:0]            idx_a;
    logic [IDX_W-1:0]            idx_b;
    logic                        done;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
  } qctl_t;

  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W:0]           v;
    logic signed [SUM_W-FRAC_BITS:0] q;
    v = (SUM_W+1)'(sum) + (SUM_W+1)'(1 << (FRAC_BITS - 1));
    q = (SUM_W-FRAC_BITS+1)'(v >>> FRAC_BITS);
    if (q > (SUM_W-FRAC_BITS+1)'((1 << (SAMPLE_W - 1)) - 1)) begin
      return SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
    end else if (q < -(SUM_W-FRAC_BITS+1)'(1 << (SAMPLE_W - 1))) begin
      return SAMPLE_W'(1 << (SAMPLE_W - 1));
    end
    return q[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== rtl/core/mp3ar_front.sv =====
`timescale 1ns / 1ps
module mp3ar_front #(
  parameter int BUTTERFLIES      = 8,
  parameter int SAMPLES_PER_BAND = 18,
  parameter int BANDS            = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [mp3ar_pkg::SAMPLE_W-1:0] sample_value,
  input  logic [mp3ar_pkg::MODE_W-1:0]        block_mode,
  input  mp3ar_pkg::qctl_t                    qctl_in,
  output logic                                q_push,
  output mp3ar_pkg::entry_t                   q_entry
);
  import mp3ar_pkg::*;

  localparam int TOTAL = BANDS * SAMPLES_PER_BAND;
  localparam int POS_W = $clog2(TOTAL);
  localparam int OFF_W = $clog2(SAMPLES_PER_BAND);
  localparam int BAND_W = (BANDS > 2) ? $clog2(BANDS) : 1;
  localparam int HW = (BUTTERFLIES > 1) ? $clog2(BUTTERFLIES) : 1;

  logic [POS_W-1:0]  pos, pos_next;
  logic [OFF_W-1:0]  off, off_next;
  logic [BAND_W-1:0] band, band_next;
  mode_t             latched_mode, mode_eff;
  logic signed [SAMPLE_W-1:0] hold [BUTTERFLIES];

  logic              accept, is_hold, is_bfly, last;
  logic [OFF_W-1:0]  mirror;
  logic [HW-1:0]     hidx_wr, hidx_rd;
  logic [POS_W-1:0]  upper_pos;

  assign sample_stall = qctl_in.full;
  assign accept = sample_valid && !qctl_in.full;
  assign last = (pos == POS_W'(TOTAL - 1));
  assign mode_eff = (pos == '0) ? mode_t'(block_mode) : latched_mode;
  assign mirror = OFF_W'(SAMPLES_PER_BAND - 1) - off;
  assign hidx_wr = mirror[HW-1:0];
  assign hidx_rd = off[HW-1:0];
  assign upper_pos = pos - POS_W'({off, 1'b0}) - POS_W'(1);

  always_comb begin
    is_hold = 1'b0;
    is_bfly = 1'b0;
    unique case (mode_eff)
      MODE_LONG: begin
        is_hold = (off >= OFF_W'(SAMPLES_PER_BAND - BUTTERFLIES)) &&
                  (band < BAND_W'(BANDS - 1));
        is_bfly = (off < OFF_W'(BUTTERFLIES)) && (band != '0);
      end
      MODE_MIXED: begin
        is_hold = (off >= OFF_W'(SAMPLES_PER_BAND - BUTTERFLIES)) && (band == '0);
        is_bfly = (off < OFF_W'(BUTTERFLIES)) && (band == BAND_W'(1));
      end
      MODE_SHORT, MODE_NONE: begin
        is_hold = 1'b0;
        is_bfly = 1'b0;
      end
      default: begin
        is_hold = 1'b0;
        is_bfly = 1'b0;
      end
    endcase
  end

  always_comb begin
    q_push = accept && !is_hold;
    q_entry.kind = is_bfly ? KIND_BFLY : KIND_PASS;
    q_entry.x = sample_value;
    q_entry.u = hold[hidx_rd];
    q_entry.sel = off[COEF_IDX_W-1:0];
    q_entry.idx_a = IDX_W'(upper_pos);
    q_entry.idx_b = IDX_W'(pos);
    q_entry.done = last;
  end

  always_comb begin
    if (last) begin
      pos_next = '0;
      off_next = '0;
      band_next = '0;
    end else if (off == OFF_W'(SAMPLES_PER_BAND - 1)) begin
      pos_next = pos + POS_W'(1);
      off_next = '0;
      band_next = band + BAND_W'(1);
    end else begin
      pos_next = pos + POS_W'(1);
      off_next = off + OFF_W'(1);
      band_next = band;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      off <= '0;
      band <= '0;
      latched_mode <= MODE_LONG;
    end else if (accept) begin
      pos <= pos_next;
      off <= off_next;
      band <= band_next;
      if (pos == '0) begin
        latched_mode <= mode_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_hold) begin
      hold[hidx_wr] <= sample_value;
    end
  end

endmodule

// ===== rtl/core/mp3ar_queue.sv =====
`timescale 1ns / 1ps
module mp3ar_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mp3ar_pkg::entry_t push_entry,
  input  logic              pop,
  output mp3ar_pkg::qctl_t  qctl,
  output mp3ar_pkg::entry_t head
);
  import mp3ar_pkg::*;

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   rd_ptr, wr_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign qctl.full = (count == QCNT_W'(QDEPTH));
  assign qctl.empty = (count == '0);
  assign do_push = push && !qctl.full;
  assign do_pop = pop && !qctl.empty;
  assign qctl.push = do_push;
  assign qctl.pop = do_pop;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/mp3ar_back.sv =====
`timescale 1ns / 1ps
module mp3ar_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [mp3ar_pkg::COEF_IDX_W-1:0]      wr_index,
  input  logic [mp3ar_pkg::REG_W-1:0]           wr_data,
  input  mp3ar_pkg::qctl_t                      qctl_in,
  input  mp3ar_pkg::entry_t                     head,
  output logic                                  pop,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [mp3ar_pkg::IDX_W-1:0]           out_index,
  output logic signed [mp3ar_pkg::SAMPLE_W-1:0] out_value,
  output logic                                  granule_done
);
  import mp3ar_pkg::*;

  logic [REG_W-1:0] coef [NUM_COEF];
  logic signed [COEF_W-1:0] cs, ca;

  logic                      p_valid;
  kind_t                     p_kind;
  logic signed [SAMPLE_W-1:0] p_x;
  logic [IDX_W-1:0]          p_idx_a, p_idx_b;
  logic                      p_done;
  logic signed [PROD_W-1:0]  pr_csu, pr_cax, pr_cau, pr_csx;

  logic                      r_valid, r_phase, r_done;
  logic signed [SAMPLE_W-1:0] r_val0, r_val1;
  logic [IDX_W-1:0]          r_idx0, r_idx1;

  logic                      r_free, p_free, p_adv;
  logic signed [SUM_W-1:0]   sum_u, sum_d;

  assign cs = coef[head.sel][REG_W-1:COEF_W];
  assign ca = coef[head.sel][COEF_W-1:0];

  assign r_free = !r_valid || (!result_stall && r_phase);
  assign p_adv = p_valid && r_free;
  assign p_free = !p_valid || r_free;
  assign pop = !qctl_in.empty && p_free;

  assign sum_u = SUM_W'(pr_csu) - SUM_W'(pr_cax);
  assign sum_d = SUM_W'(pr_cau) + SUM_W'(pr_csx);

  assign result_valid = r_valid;
  assign out_index = r_phase ? r_idx1 : r_idx0;
  assign out_value = r_phase ? r_val1 : r_val0;
  assign granule_done = r_phase && r_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef[i] <= '0;
      end
    end else if (wr_en) begin
      coef[wr_index] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_kind <= head.kind;
      p_x <= head.x;
      p_idx_a <= head.idx_a;
      p_idx_b <= head.idx_b;
      p_done <= head.done;
      pr_csu <= head.u * cs;
      pr_cax <= head.x * ca;
      pr_cau <= head.u * ca;
      pr_csx <= head.x * cs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      r_phase <= 1'b0;
    end else if (p_adv) begin
      r_valid <= 1'b1;
      r_phase <= (p_kind == KIND_PASS);
    end else if (r_valid && !result_stall) begin
      if (r_phase) begin
        r_valid <= 1'b0;
      end else begin
        r_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      r_idx0 <= p_idx_a;
      r_idx1 <= p_idx_b;
      r_done <= p_done;
      r_val0 <= round_sat(sum_u);
      r_val1 <= (p_kind == KIND_BFLY) ? round_sat(sum_d) : p_x;
    end
  end

endmodule

// ===== rtl/core/mp3_alias_reduction_butterfly_unit.sv =====
`timescale 1ns / 1ps
// Layer III alias reduction for one granule of BANDS*SAMPLES_PER_BAND samples, fed in index
// order, one sample per cycle. Block mode is taken from the first sample of each granule. The
// upper samples of a band are held inside until their partner arrives; each butterfly then
// yields two results (upper first), all other samples pass through, and the held samples yield
// nothing at their own transfer. Input is accepted every cycle while an eight-entry queue in
// front of the arithmetic has room; results leave at one per cycle while result_stall is low,
// and a butterfly's two results leave one after the other. Each result passes through the queue,
// the multiply stage and the round and saturate stage. Coefficients must be written through the
// write port only while no granule data is in flight; the block itself does not enforce this.
module mp3_alias_reduction_butterfly_unit #(
  parameter int BUTTERFLIES      = 8,
  parameter int SAMPLES_PER_BAND = 18,
  parameter int BANDS            = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [mp3ar_pkg::COEF_IDX_W-1:0]      wr_index,
  input  logic [mp3ar_pkg::REG_W-1:0]           wr_data,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [mp3ar_pkg::SAMPLE_W-1:0] sample_value,
  input  logic [mp3ar_pkg::MODE_W-1:0]          block_mode,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [mp3ar_pkg::IDX_W-1:0]           out_index,
  output logic signed [mp3ar_pkg::SAMPLE_W-1:0] out_value,
  output logic                                  granule_done
);
  import mp3ar_pkg::*;

  qctl_t  qctl;
  entry_t push_entry, head;
  logic   push, pop;

  mp3ar_front #(
    .BUTTERFLIES(BUTTERFLIES),
    .SAMPLES_PER_BAND(SAMPLES_PER_BAND),
    .BANDS(BANDS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_value(sample_value),
    .block_mode(block_mode),
    .qctl_in(qctl),
    .q_push(push),
    .q_entry(push_entry)
  );

  mp3ar_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(pop),
    .qctl(qctl),
    .head(head)
  );

  mp3ar_back u_back (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .qctl_in(qctl),
    .head(head),
    .pop(pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_index(out_index),
    .out_value(out_value),
    .granule_done(granule_done)
  );

endmodule

// ===== rtl/core/mp3ar_checker.sv =====
`timescale 1ns / 1ps
module mp3ar_checker #(
  parameter int SAMPLES_PER_BAND = 18,
  parameter int BANDS            = 32
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  result_valid,
  input logic                                  result_stall,
  input logic [mp3ar_pkg::IDX_W-1:0]           out_index,
  input logic signed [mp3ar_pkg::SAMPLE_W-1:0] out_value,
  input logic                                  granule_done
);
  import mp3ar_pkg::*;

  localparam int TOTAL = BANDS * SAMPLES_PER_BAND;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOTAL - 1);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    !rst && result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    !rst && result_valid && result_stall |=>
      $stable(out_index) && $stable(out_value) && $stable(granule_done))
    else $error("result payload changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && granule_done |-> out_index == LAST_IDX)
    else $error("granule end flagged on a sample other than the last");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result present right after reset");

endmodule

bind mp3_alias_reduction_butterfly_unit mp3ar_checker #(
  .SAMPLES_PER_BAND(SAMPLES_PER_BAND),
  .BANDS(BANDS)
) u_checker (
  .clk(clk),
  .rst(rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .out_index(out_index),
  .out_value(out_value),
  .granule_done(granule_done)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import mp3ar_pkg::*;

  localparam int SPB         = 18;
  localparam int NBANDS      = 32;
  localparam int NBFLY       = 8;
  localparam int GRANULE_LEN = NBANDS * SPB;
  localparam int DIRECTED_N  = 25;
  localparam int NUM_PHASES  = 5;
  localparam int SLICE_LEN   = 170;
  localparam int SETTLE      = 8;
  localparam logic signed [SAMPLE_W-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMIN = 24'sh800000;
  localparam logic [REG_W-1:0] EXTREME_COEF [5] = '{
    32'h7FFF8000, 32'h80008000, 32'h7FFF7FFF, 32'h80007FFF, 32'h00000000
  };

  typedef struct {
    logic [IDX_W-1:0]           index;
    logic signed [SAMPLE_W-1:0] value;
    logic                       done;
  } reduced_t;

  class granule_scoreboard;
    logic [REG_W-1:0]           coef_pair [NUM_COEF];
    logic signed [SAMPLE_W-1:0] upper_hold [NBFLY];
    int unsigned                position;
    mode_t                      granule_mode;
    reduced_t                   pending_outputs [$];
    int                         errors;
    int                         samples_in;
    int                         results_seen;
    int                         butterflies;

    function new();
      foreach (coef_pair[i]) coef_pair[i] = '0;
      foreach (upper_hold[i]) upper_hold[i] = '0;
      position = 0;
      granule_mode = MODE_LONG;
      errors = 0;
      samples_in = 0;
      results_seen = 0;
      butterflies = 0;
    endfunction

    function void set_coef(logic [COEF_IDX_W-1:0] idx, logic [REG_W-1:0] data);
      coef_pair[idx] = data;
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction

    function logic signed [SAMPLE_W-1:0] round_saturate(longint sum);
      longint q;
      q = (sum + 64'sd16384) >>> FRAC_BITS;
      if (q > longint'(SMAX)) q = longint'(SMAX);
      if (q < longint'(SMIN)) q = longint'(SMIN);
      return q[SAMPLE_W-1:0];
    endfunction

    function void push_result(int unsigned idx, logic signed [SAMPLE_W-1:0] v, logic d);
      reduced_t r;
      r.index = idx[IDX_W-1:0];
      r.value = v;
      r.done = d;
      pending_outputs.push_back(r);
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] x, logic [MODE_W-1:0] m);
      int unsigned band;
      int unsigned off;
      int unsigned bounds;
      longint      cs;
      longint      ca;
      longint      u;
      longint      d;
      samples_in++;
      if (position == 0) granule_mode = mode_t'(m);
      band = position / SPB;
      off = position % SPB;
      case (granule_mode)
        MODE_LONG:  bounds = NBANDS - 1;
        MODE_MIXED: bounds = 1;
        default:    bounds = 0;
      endcase
      if (off >= SPB - NBFLY && band < bounds) begin
        upper_hold[SPB - 1 - off] = x;
      end else if (off < NBFLY && band >= 1 && band - 1 < bounds) begin
        cs = $signed(coef_pair[off][31:16]);
        ca = $signed(coef_pair[off][15:0]);
        u = upper_hold[off];
        d = x;
        push_result((band - 1) * SPB + (SPB - 1 - off), round_saturate(cs * u - ca * d), 1'b0);
        push_result(position, round_saturate(ca * u + cs * d), position == GRANULE_LEN - 1);
        butterflies++;
      end else begin
        push_result(position, x, position == GRANULE_LEN - 1);
      end
      position = (position + 1) % GRANULE_LEN;
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, logic signed [SAMPLE_W-1:0] v, logic d);
      reduced_t e;
      results_seen++;
      if (pending_outputs.size() == 0) begin
        $error("unexpected result: out_index %0d out_value %0d", idx, v);
        errors++;
        return;
      end
      e = pending_outputs.pop_front();
      if (idx !== e.index) begin
        $error("out_index: expected %0d, actual %0d", e.index, idx);
        errors++;
      end
      if (v !== e.value) begin
        $error("out_value: expected %0d, actual %0d", e.value, v);
        errors++;
      end
      if (d !== e.done) begin
        $error("granule_done: expected %0b, actual %0b", e.done, d);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       wr_en;
  logic [COEF_IDX_W-1:0]      wr_index;
  logic [REG_W-1:0]           wr_data;
  logic                       sample_valid;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [MODE_W-1:0]          block_mode;
  logic                       result_valid;
  logic                       result_stall;
  logic [IDX_W-1:0]           out_index;
  logic signed [SAMPLE_W-1:0] out_value;
  logic                       granule_done;

  granule_scoreboard board = new();
  int burst_left = 0;

  mp3_alias_reduction_butterfly_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_value (sample_value),
    .block_mode   (block_mode),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_index    (out_index),
    .out_value    (out_value),
    .granule_done (granule_done)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst && wr_en) board.set_coef(wr_index, wr_data);
    if (!rst && sample_valid && !sample_stall) board.note_sample(sample_value, block_mode);
    if (!rst && result_valid && !result_stall) board.check_result(out_index, out_value,
                                                                 granule_done);
  end

  initial begin
    int unsigned pick;
    int          run;
    logic        level;
    result_stall = 1'b0;
    @(negedge rst);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        level = 1'b0;
        run = $urandom_range(30, 150);
      end else if (pick < 12) begin
        level = 1'b1;
        run = $urandom_range(8, 20);
      end else if (pick < 45) begin
        level = 1'b1;
        run = $urandom_range(1, 3);
      end else begin
        level = 1'b0;
        run = $urandom_range(1, 4);
      end
      result_stall <= level;
      repeat (run) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int unsigned pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      burst_left = $urandom_range(40, 120);
      return 0;
    end
    if (pick < 68) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 20);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int unsigned pick;
    logic [31:0] r;
    pick = $urandom_range(0, 15);
    r = $urandom;
    case (pick)
      0, 1:    return SMAX;
      2, 3:    return SMIN;
      4:       return '0;
      5:       return $signed(SAMPLE_W'($urandom_range(0, 64))) - 24'sd32;
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  function automatic logic [REG_W-1:0] coef_choice(int phase, int i);
    case (phase)
      0: return EXTREME_COEF[i % 5];
      1: return 32'h80008000;
      3: return 32'h7FFF7FFF;
      4: return ($urandom_range(0, 1) == 0) ? EXTREME_COEF[$urandom_range(0, 4)] : $urandom;
      default: return $urandom;
    endcase
  endfunction

  // The first granule runs in long block mode and the second one in mixed block mode.
  function automatic mode_t granule_plan(int g);
    if (g == 0) return MODE_LONG;
    return MODE_MIXED;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input logic [MODE_W-1:0] m,
                             input int gap);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_value <= v;
    block_mode <= m;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (board.pending() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic load_coefs(input int phase);
    for (int i = 0; i < NUM_COEF; i++) begin
      wr_en <= 1'b1;
      wr_index <= COEF_IDX_W'(i);
      wr_data <= coef_choice(phase, i);
      @(negedge clk);
    end
    wr_en <= 1'b0;
  endtask

  task automatic run_slice(input int first, input int len, input bit directed);
    logic signed [SAMPLE_W-1:0] v;
    logic [MODE_W-1:0]          m;
    logic signed [SAMPLE_W-1:0] lead [DIRECTED_N];
    int                         p;
    lead = '{SMAX, SMIN, 24'sd0, -24'sd1, 24'sd1, 24'sh400000, -24'sh400000, SMAX, SMIN, SMAX,
             SMIN, SMAX, SMIN, SMIN, SMAX, SMAX, SMIN, SMAX, SMAX, SMIN, SMIN, SMAX, -24'sd1,
             24'sd0, 24'sd1};
    for (int k = 0; k < len; k++) begin
      p = first + k;
      if (directed && k < DIRECTED_N) v = lead[k];
      else v = random_sample();
      if (p % GRANULE_LEN == 0) m = granule_plan(p / GRANULE_LEN);
      else m = MODE_W'($urandom_range(0, 3));
      send_sample(v, m, (directed && k < DIRECTED_N) ? 0 : pick_gap());
    end
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    sample_valid = 1'b0;
    sample_value = '0;
    block_mode = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      load_coefs(ph);
      run_slice(ph * SLICE_LEN, SLICE_LEN, ph == 0);
    end
    wait_idle();
    $display("Streamed %0d samples: a whole long block granule and the start of a mixed one,",
             board.samples_in);
    $display("with %0d coefficient sets loaded while idle; %0d results checked, %0d butterflies.",
             NUM_PHASES, board.results_seen, board.butterflies);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mp3ar_pkg.sv
rtl/core/mp3ar_front.sv
rtl/core/mp3ar_queue.sv
rtl/core/mp3ar_back.sv
rtl/core/mp3_alias_reduction_butterfly_unit.sv
rtl/core/mp3ar_checker.sv
tb/tb.sv
